// File: rtl/core/si_pkg.sv
`default_nettype none
package si_pkg;

    localparam int COORD_W = 16;
    localparam int FRAC_W  = 16;
    localparam int OUT_W   = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int DPROD_W = 2 * DIFF_W;
    localparam int DET_W   = DPROD_W + 1;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MPROD_W = CROSS_W + DIFF_W;
    localparam int NUM_W   = MPROD_W + 1;
    localparam int MAG_W   = NUM_W - 1;
    localparam int BND_W   = COORD_W + DET_W + 1;
    localparam int REM_W   = DET_W + 1;
    localparam int QUO_W   = OUT_W;
    localparam int DVD_W   = QUO_W;
    localparam int DVD_LO  = QUO_W - FRAC_W;
    localparam int STEPS   = QUO_W;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } si_lane_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [DET_W-1:0] den;
        si_lane_t         x;
        si_lane_t         y;
    } si_div_t;

endpackage
`default_nettype wire

// File: rtl/core/si_in_if.sv
`default_nettype none
interface si_in_if;
    logic           valid;
    logic           ready;
    si_pkg::coord_t a_start_x;
    si_pkg::coord_t a_start_y;
    si_pkg::coord_t a_end_x;
    si_pkg::coord_t a_end_y;
    si_pkg::coord_t b_start_x;
    si_pkg::coord_t b_start_y;
    si_pkg::coord_t b_end_x;
    si_pkg::coord_t b_end_y;

    modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y, input ready);
    modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface
`default_nettype wire

// File: rtl/core/si_out_if.sv
`default_nettype none
interface si_out_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [si_pkg::OUT_W-1:0]     cross_x;
    logic signed [si_pkg::OUT_W-1:0]     cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

// File: rtl/core/si_front.sv
`default_nettype none
module si_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire si_pkg::coord_t  ax0,
    input  wire si_pkg::coord_t  ay0,
    input  wire si_pkg::coord_t  ax1,
    input  wire si_pkg::coord_t  ay1,
    input  wire si_pkg::coord_t  bx0,
    input  wire si_pkg::coord_t  by0,
    input  wire si_pkg::coord_t  bx1,
    input  wire si_pkg::coord_t  by1,
    output si_pkg::si_div_t      div_out
);

    logic [4:0] v_reg;

    logic signed [si_pkg::DIFF_W-1:0]  s1_dax_reg, s1_day_reg, s1_dbx_reg, s1_dby_reg;
    logic signed [si_pkg::PROD_W-1:0]  s1_pa_reg, s1_pb_reg, s1_pc_reg, s1_pd_reg;
    logic signed [si_pkg::DPROD_W-1:0] s1_d1_reg, s1_d2_reg;
    si_pkg::coord_t s1_xlo_reg, s1_xhi_reg, s1_ylo_reg, s1_yhi_reg;
    logic signed [si_pkg::DIFF_W-1:0]  dax_next, day_next, dbx_next, dby_next;

    logic signed [si_pkg::DIFF_W-1:0]  s2_dax_reg, s2_day_reg, s2_dbx_reg, s2_dby_reg;
    logic signed [si_pkg::DET_W-1:0]   s2_d_reg;
    logic signed [si_pkg::CROSS_W-1:0] s2_pre_reg, s2_post_reg;
    si_pkg::coord_t s2_xlo_reg, s2_xhi_reg, s2_ylo_reg, s2_yhi_reg;

    logic signed [si_pkg::MPROD_W-1:0] s3_m1_reg, s3_m2_reg, s3_m3_reg, s3_m4_reg;
    logic signed [si_pkg::DET_W-1:0]   s3_d_reg;
    si_pkg::coord_t s3_xlo_reg, s3_xhi_reg, s3_ylo_reg, s3_yhi_reg;

    logic signed [si_pkg::NUM_W-1:0]   nx_next, ny_next;
    logic signed [si_pkg::NUM_W-1:0]   s4_nx_reg, s4_ny_reg;
    logic [si_pkg::DET_W-1:0]          s4_den_reg;
    logic                              s4_zero_reg;
    si_pkg::coord_t s4_xlo_reg, s4_xhi_reg, s4_ylo_reg, s4_yhi_reg;

    logic signed [si_pkg::BND_W-1:0]   s5_bxl_reg, s5_bxh_reg, s5_byl_reg, s5_byh_reg;
    logic signed [si_pkg::NUM_W-1:0]   s5_nx_reg, s5_ny_reg;
    logic [si_pkg::DET_W-1:0]          s5_den_reg;
    logic                              s5_zero_reg;
    logic signed [si_pkg::DET_W:0]     den_s;

    logic signed [si_pkg::BND_W-1:0]   nx_w, ny_w;
    logic [si_pkg::MAG_W-1:0]          magx, magy;
    si_pkg::si_div_t                   div_next, div_reg;

    function automatic si_pkg::coord_t cmin(si_pkg::coord_t a, si_pkg::coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic si_pkg::coord_t cmax(si_pkg::coord_t a, si_pkg::coord_t b);
        return (a > b) ? a : b;
    endfunction

    assign dax_next = si_pkg::DIFF_W'(ax0) - si_pkg::DIFF_W'(ax1);
    assign day_next = si_pkg::DIFF_W'(ay0) - si_pkg::DIFF_W'(ay1);
    assign dbx_next = si_pkg::DIFF_W'(bx0) - si_pkg::DIFF_W'(bx1);
    assign dby_next = si_pkg::DIFF_W'(by0) - si_pkg::DIFF_W'(by1);

    assign nx_next = si_pkg::NUM_W'(s3_m1_reg) - si_pkg::NUM_W'(s3_m2_reg);
    assign ny_next = si_pkg::NUM_W'(s3_m3_reg) - si_pkg::NUM_W'(s3_m4_reg);
    assign den_s   = $signed({1'b0, s4_den_reg});

    assign nx_w = si_pkg::BND_W'(s5_nx_reg);
    assign ny_w = si_pkg::BND_W'(s5_ny_reg);
    assign magx = s5_nx_reg[si_pkg::NUM_W-1] ? si_pkg::MAG_W'(-s5_nx_reg)
                                              : si_pkg::MAG_W'(s5_nx_reg);
    assign magy = s5_ny_reg[si_pkg::NUM_W-1] ? si_pkg::MAG_W'(-s5_ny_reg)
                                              : si_pkg::MAG_W'(s5_ny_reg);

    always_comb
    begin
        div_next.valid = v_reg[4];
        div_next.hit   = !s5_zero_reg && (nx_w >= s5_bxl_reg) && (nx_w <= s5_bxh_reg)
                         && (ny_w >= s5_byl_reg) && (ny_w <= s5_byh_reg);
        div_next.den   = s5_den_reg;
        div_next.x.rem = si_pkg::REM_W'(magx[si_pkg::MAG_W-1:si_pkg::DVD_LO]);
        div_next.x.dvd = {magx[si_pkg::DVD_LO-1:0], {si_pkg::FRAC_W{1'b0}}};
        div_next.x.quo = '0;
        div_next.x.neg = s5_nx_reg[si_pkg::NUM_W-1];
        div_next.y.rem = si_pkg::REM_W'(magy[si_pkg::MAG_W-1:si_pkg::DVD_LO]);
        div_next.y.dvd = {magy[si_pkg::DVD_LO-1:0], {si_pkg::FRAC_W{1'b0}}};
        div_next.y.quo = '0;
        div_next.y.neg = s5_ny_reg[si_pkg::NUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= '0;
            div_reg     <= '0;
        end
        else if (en)
        begin
            v_reg       <= {v_reg[3:0], in_valid};
            div_reg     <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dax_reg <= dax_next;
            s1_day_reg <= day_next;
            s1_dbx_reg <= dbx_next;
            s1_dby_reg <= dby_next;
            s1_pa_reg  <= si_pkg::PROD_W'(ax0) * si_pkg::PROD_W'(ay1);
            s1_pb_reg  <= si_pkg::PROD_W'(ay0) * si_pkg::PROD_W'(ax1);
            s1_pc_reg  <= si_pkg::PROD_W'(bx0) * si_pkg::PROD_W'(by1);
            s1_pd_reg  <= si_pkg::PROD_W'(by0) * si_pkg::PROD_W'(bx1);
            s1_d1_reg  <= si_pkg::DPROD_W'(dax_next) * si_pkg::DPROD_W'(dby_next);
            s1_d2_reg  <= si_pkg::DPROD_W'(day_next) * si_pkg::DPROD_W'(dbx_next);
            s1_xlo_reg <= cmax(cmin(ax0, ax1), cmin(bx0, bx1));
            s1_xhi_reg <= cmin(cmax(ax0, ax1), cmax(bx0, bx1));
            s1_ylo_reg <= cmax(cmin(ay0, ay1), cmin(by0, by1));
            s1_yhi_reg <= cmin(cmax(ay0, ay1), cmax(by0, by1));

            s2_dax_reg  <= s1_dax_reg;
            s2_day_reg  <= s1_day_reg;
            s2_dbx_reg  <= s1_dbx_reg;
            s2_dby_reg  <= s1_dby_reg;
            s2_d_reg    <= si_pkg::DET_W'(s1_d1_reg) - si_pkg::DET_W'(s1_d2_reg);
            s2_pre_reg  <= si_pkg::CROSS_W'(s1_pa_reg) - si_pkg::CROSS_W'(s1_pb_reg);
            s2_post_reg <= si_pkg::CROSS_W'(s1_pc_reg) - si_pkg::CROSS_W'(s1_pd_reg);
            s2_xlo_reg  <= s1_xlo_reg;
            s2_xhi_reg  <= s1_xhi_reg;
            s2_ylo_reg  <= s1_ylo_reg;
            s2_yhi_reg  <= s1_yhi_reg;

            s3_m1_reg  <= si_pkg::MPROD_W'(s2_pre_reg) * si_pkg::MPROD_W'(s2_dbx_reg);
            s3_m2_reg  <= si_pkg::MPROD_W'(s2_dax_reg) * si_pkg::MPROD_W'(s2_post_reg);
            s3_m3_reg  <= si_pkg::MPROD_W'(s2_pre_reg) * si_pkg::MPROD_W'(s2_dby_reg);
            s3_m4_reg  <= si_pkg::MPROD_W'(s2_day_reg) * si_pkg::MPROD_W'(s2_post_reg);
            s3_d_reg   <= s2_d_reg;
            s3_xlo_reg <= s2_xlo_reg;
            s3_xhi_reg <= s2_xhi_reg;
            s3_ylo_reg <= s2_ylo_reg;
            s3_yhi_reg <= s2_yhi_reg;

            s4_nx_reg   <= s3_d_reg[si_pkg::DET_W-1] ? -nx_next : nx_next;
            s4_ny_reg   <= s3_d_reg[si_pkg::DET_W-1] ? -ny_next : ny_next;
            s4_den_reg  <= s3_d_reg[si_pkg::DET_W-1] ? si_pkg::DET_W'(-s3_d_reg)
                                                     : si_pkg::DET_W'(s3_d_reg);
            s4_zero_reg <= (s3_d_reg == '0);
            s4_xlo_reg  <= s3_xlo_reg;
            s4_xhi_reg  <= s3_xhi_reg;
            s4_ylo_reg  <= s3_ylo_reg;
            s4_yhi_reg  <= s3_yhi_reg;

            s5_bxl_reg  <= si_pkg::BND_W'(s4_xlo_reg) * si_pkg::BND_W'(den_s);
            s5_bxh_reg  <= si_pkg::BND_W'(s4_xhi_reg) * si_pkg::BND_W'(den_s);
            s5_byl_reg  <= si_pkg::BND_W'(s4_ylo_reg) * si_pkg::BND_W'(den_s);
            s5_byh_reg  <= si_pkg::BND_W'(s4_yhi_reg) * si_pkg::BND_W'(den_s);
            s5_nx_reg   <= s4_nx_reg;
            s5_ny_reg   <= s4_ny_reg;
            s5_den_reg  <= s4_den_reg;
            s5_zero_reg <= s4_zero_reg;
        end
    end

    assign div_out = div_reg;

endmodule
`default_nettype wire

// File: rtl/core/si_div_cell.sv
`default_nettype none
module si_div_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire si_pkg::si_div_t prev,
    output si_pkg::si_div_t      next
);

    si_pkg::si_div_t cell_reg, cell_next;

    function automatic si_pkg::si_lane_t step(si_pkg::si_lane_t l,
                                              logic [si_pkg::DET_W-1:0] den);
        logic [si_pkg::REM_W-1:0] r2;
        logic [si_pkg::REM_W-1:0] dw;
        si_pkg::si_lane_t         o;
        r2 = {l.rem[si_pkg::REM_W-2:0], l.dvd[si_pkg::DVD_W-1]};
        dw = {1'b0, den};
        o.neg = l.neg;
        o.dvd = {l.dvd[si_pkg::DVD_W-2:0], 1'b0};
        if (r2 >= dw)
        begin
            o.rem = r2 - dw;
            o.quo = {l.quo[si_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2;
            o.quo = {l.quo[si_pkg::QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb
    begin
        cell_next       = prev;
        cell_next.x     = step(prev.x, prev.den);
        cell_next.y     = step(prev.y, prev.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (en)
            cell_reg <= cell_next;
    end

    assign next = cell_reg;

endmodule
`default_nettype wire

// File: rtl/core/segment_intersection.sv
// Pipeline: 39 register stages (6 front stages, 32 divider cells, 1 output
// register).
// Throughput: one item per cycle; the whole pipeline holds only while a
// finished result waits at the output register.
// Reset: rst_n clears all valid flags asynchronously; no items are in flight.
`default_nettype none
module segment_intersection (
    input  wire logic clk,
    input  wire logic rst_n,
    si_in_if.sink     pairs,
    si_out_if.source  result
);

    localparam int OW = si_pkg::OUT_W;

    logic            adv;
    logic            out_valid_reg;
    logic            out_hit_reg;
    logic signed [OW-1:0] out_x_reg, out_y_reg;
    si_pkg::si_div_t chain [0:si_pkg::STEPS];
    si_pkg::si_div_t last;

    function automatic logic [OW-1:0] fix(si_pkg::si_lane_t l);
        logic [OW-1:0] pos_lim;
        logic [OW-1:0] neg_lim;
        pos_lim = {1'b0, {(OW-1){1'b1}}};
        neg_lim = {1'b1, {(OW-1){1'b0}}};
        if (l.neg)
            return (l.quo > neg_lim) ? neg_lim : OW'(-l.quo);
        else
            return (l.quo > pos_lim) ? pos_lim : OW'(l.quo);
    endfunction

    assign adv         = !out_valid_reg || result.ready;
    assign pairs.ready = adv;

    si_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (pairs.valid),
        .ax0      (pairs.a_start_x),
        .ay0      (pairs.a_start_y),
        .ax1      (pairs.a_end_x),
        .ay1      (pairs.a_end_y),
        .bx0      (pairs.b_start_x),
        .by0      (pairs.b_start_y),
        .bx1      (pairs.b_end_x),
        .by1      (pairs.b_end_y),
        .div_out  (chain[0])
    );

    for (genvar i = 0; i < si_pkg::STEPS; i++)
    begin : g_cell
        si_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .prev  (chain[i]),
            .next  (chain[i+1])
        );
    end

    assign last = chain[si_pkg::STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg <= last.hit;
            out_x_reg   <= last.hit ? fix(last.x) : '0;
            out_y_reg   <= last.hit ? fix(last.y) : '0;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.hit     = out_hit_reg;
    assign result.cross_x = out_x_reg;
    assign result.cross_y = out_y_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |-> result.cross_x == '0 && result.cross_y == '0)
        else $error("miss result carries a nonzero point");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !pairs.ready)
        else $error("input taken while result is stalled");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        last.valid && last.hit |-> last.x.rem < {1'b0, last.den}
                                   && last.y.rem < {1'b0, last.den})
        else $error("divider remainder out of range");

    a_hit_nonzero_den: assert property (@(posedge clk) disable iff (!rst_n)
        chain[0].valid && chain[0].hit |-> chain[0].den != '0)
        else $error("hit with zero determinant");

endmodule
`default_nettype wire

// File: tb/seg_checker.sv
`timescale 1ns / 1ps
module seg_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    si_in_if.sink     pairs,
    si_out_if.sink    result,
    output int        fail_count,
    output int        pending
);
    typedef struct {
        logic               hit;
        logic signed [31:0] cross_x;
        logic signed [31:0] cross_y;
    } crossing_t;

    crossing_t expected_crossings[$];

    function automatic logic signed [31:0] scale_q16(logic signed [127:0] num,
                                                    logic signed [127:0] den);
        logic signed [127:0] q;
        q = (num <<< 16) / den;
        if (q > 128'sd2147483647)
            return 32'h7fffffff;
        if (q < -128'sd2147483648)
            return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic crossing_t predict_crossing(logic signed [15:0] ax0,
        logic signed [15:0] ay0, logic signed [15:0] ax1, logic signed [15:0] ay1,
        logic signed [15:0] bx0, logic signed [15:0] by0, logic signed [15:0] bx1,
        logic signed [15:0] by1);
        crossing_t c;
        logic signed [127:0] dax, day, dbx, dby, d, pre, post, nx, ny;
        logic signed [127:0] xlo, xhi, ylo, yhi;
        c.hit = 1'b0;
        c.cross_x = '0;
        c.cross_y = '0;
        dax = ax0 - ax1;
        day = ay0 - ay1;
        dbx = bx0 - bx1;
        dby = by0 - by1;
        d = dax * dby - day * dbx;
        if (d == 0)
            return c;
        pre = 128'(ax0) * ay1 - 128'(ay0) * ax1;
        post = 128'(bx0) * by1 - 128'(by0) * bx1;
        nx = pre * dbx - dax * post;
        ny = pre * dby - day * post;
        if (d < 0)
        begin
            d = -d;
            nx = -nx;
            ny = -ny;
        end
        xlo = (ax0 < ax1 ? ax0 : ax1) > (bx0 < bx1 ? bx0 : bx1)
            ? (ax0 < ax1 ? ax0 : ax1) : (bx0 < bx1 ? bx0 : bx1);
        xhi = (ax0 > ax1 ? ax0 : ax1) < (bx0 > bx1 ? bx0 : bx1)
            ? (ax0 > ax1 ? ax0 : ax1) : (bx0 > bx1 ? bx0 : bx1);
        ylo = (ay0 < ay1 ? ay0 : ay1) > (by0 < by1 ? by0 : by1)
            ? (ay0 < ay1 ? ay0 : ay1) : (by0 < by1 ? by0 : by1);
        yhi = (ay0 > ay1 ? ay0 : ay1) < (by0 > by1 ? by0 : by1)
            ? (ay0 > ay1 ? ay0 : ay1) : (by0 > by1 ? by0 : by1);
        if (nx < xlo * d || nx > xhi * d || ny < ylo * d || ny > yhi * d)
            return c;
        c.hit = 1'b1;
        c.cross_x = scale_q16(nx, d);
        c.cross_y = scale_q16(ny, d);
        return c;
    endfunction

    assign pending = expected_crossings.size();

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_crossings.delete();
        end
        else
        begin
            if (pairs.valid && pairs.ready)
                expected_crossings.push_back(predict_crossing(pairs.a_start_x,
                    pairs.a_start_y, pairs.a_end_x, pairs.a_end_y, pairs.b_start_x,
                    pairs.b_start_y, pairs.b_end_x, pairs.b_end_y));
            if (result.valid && result.ready)
            begin
                if (expected_crossings.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result item: hit %0b x %0d y %0d",
                                 result.hit, result.cross_x, result.cross_y);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_crossings.pop_front();
                    if (result.hit !== e.hit || result.cross_x !== e.cross_x
                        || result.cross_y !== e.cross_y)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch: expected %0b %0d %0d, got %0b %0d %0d",
                                     e.hit, e.cross_x, e.cross_y, result.hit,
                                     result.cross_x, result.cross_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/tb_segment_intersection.sv
`timescale 1ns / 1ps
module tb_segment_intersection;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   sender_idle;
    int   receiver_idle;
    int   quiet_cycles;
    bit   hold_receiver;
    bit   started;

    si_in_if  pairs ();
    si_out_if result ();

    segment_intersection dut (.clk(clk), .rst_n(rst_n), .pairs(pairs), .result(result));
    seg_checker checker_i (.clk(clk), .rst_n(rst_n), .pairs(pairs), .result(result),
                           .fail_count(fail_count), .pending(pending));

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (hold_receiver || !started)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(99) >= receiver_idle);
    end

    always @(posedge clk)
    begin
        if ((pairs.valid && pairs.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_pair(input logic [15:0] c[8]);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle)
        begin
            pairs.valid <= 1'b0;
            @(negedge clk);
        end
        pairs.valid <= 1'b1;
        pairs.a_start_x <= c[0];
        pairs.a_start_y <= c[1];
        pairs.a_end_x <= c[2];
        pairs.a_end_y <= c[3];
        pairs.b_start_x <= c[4];
        pairs.b_start_y <= c[5];
        pairs.b_end_x <= c[6];
        pairs.b_end_y <= c[7];
        @(posedge clk);
        while (!pairs.ready)
            @(posedge clk);
    endtask

    task automatic send_random_pair();
        logic [15:0] c[8];
        int span;
        int kind;
        kind = $urandom_range(9);
        span = (kind < 4) ? 40 : ((kind < 7) ? 2000 : 32767);
        for (int i = 0; i < 8; i++)
            c[i] = (kind == 9) ? 16'($urandom)
                   : 16'($signed($urandom_range(2 * span)) - span);
        if (kind == 8)
        begin
            c[6] = c[4] + (c[2] - c[0]);
            c[7] = c[5] + (c[3] - c[1]);
        end
        send_pair(c);
    endtask

    initial
    begin
        logic [15:0] d[8];
        rst_n = 1'b0;
        started = 1'b0;
        hold_receiver = 1'b0;
        quiet_cycles = 0;
        sender_idle = 38;
        receiver_idle = 48;
        pairs.valid = 1'b0;
        pairs.a_start_x = '0;
        pairs.a_start_y = '0;
        pairs.a_end_x = '0;
        pairs.a_end_y = '0;
        pairs.b_start_x = '0;
        pairs.b_start_y = '0;
        pairs.b_end_x = '0;
        pairs.b_end_y = '0;
        result.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        started = 1'b1;

        d = '{16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd10, 16'sd10, 16'sd0};
        send_pair(d);
        d = '{16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd1, 16'sd0, 16'sd11, 16'sd10};
        send_pair(d);
        d = '{16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd2, 16'sd2, 16'sd8, 16'sd8};
        send_pair(d);
        d = '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd9, 16'sd1};
        send_pair(d);
        d = '{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd10, 16'sd5, 16'sd10, -16'sd5};
        send_pair(d);
        d = '{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd10, 16'sd5, 16'sd10, -16'sd5};
        send_pair(d);
        d = '{16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd0, 16'sd1, 16'sd3, 16'sd0};
        send_pair(d);
        d = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
              16'h7fff, 16'h8000};
        send_pair(d);
        d = '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h7fff, 16'h7ffe};
        send_pair(d);
        d = '{16'h8000, 16'h0000, 16'h7fff, 16'h0001, 16'h0000, 16'h8000,
              16'h0001, 16'h7fff};
        send_pair(d);
        d = '{16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0001,
              16'h0001, 16'hffff};
        send_pair(d);
        d = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h7fff};
        send_pair(d);

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle = (phase == 0) ? 38 : ((phase == 1) ? 48 : 0);
            receiver_idle = (phase == 0) ? 48 : ((phase == 1) ? 38 : 0);
            for (int n = 0; n < 450; n++)
            begin
                if (phase == 2 && n == 100)
                    hold_receiver = 1'b1;
                if (phase == 2 && n == 100)
                    fork
                        begin
                            repeat (300) @(posedge clk);
                            hold_receiver = 1'b0;
                        end
                    join_none
                send_random_pair();
            end
        end
        @(negedge clk);
        pairs.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: segment_intersection.f
rtl/core/si_pkg.sv
rtl/core/si_in_if.sv
rtl/core/si_out_if.sv
rtl/core/si_front.sv
rtl/core/si_div_cell.sv
rtl/core/segment_intersection.sv
tb/seg_checker.sv
tb/tb_segment_intersection.sv
